>>> src/lbf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Lorentz boost block.
// No dependencies.
package lbf_pkg;

  localparam int FACTOR_W    = 32;
  localparam int FACTOR_FRAC = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int STATUS_W    = 2;
  localparam int MAG_W       = 61;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE  = 32'h0100_0000;
  localparam logic [FACTOR_W-1:0] FACTOR_HALF = 32'h0080_0000;
  localparam logic [FACTOR_W-1:0] FACTOR_MAX  = 32'hFFFF_FFFF;
  localparam logic [MAG_W-1:0]    MAG_LIM     = 61'h1000_0000_0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_BETA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_Z = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT     = 2'd2;

  typedef enum logic [2:0] {
    SU_IDLE,
    SU_SUM,
    SU_CHECK,
    SU_DIV,
    SU_SQRT,
    SU_MUL,
    SU_KDIV
  } su_state_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] gamma;
    logic [FACTOR_W-1:0] k;
    logic                vok;
  } lbf_factors_t;

  // magnitude limited to 2^60
  function automatic logic [MAG_W-1:0] clamp_mag(input logic [127:0] m);
    clamp_mag = (m > 128'(MAG_LIM)) ? MAG_LIM : m[MAG_W-1:0];
  endfunction

  function automatic logic signed [63:0] apply_sign(input logic neg,
                                                    input logic [MAG_W-1:0] mag);
    logic signed [63:0] v;
    v = signed'(64'(mag));
    apply_sign = neg ? -v : v;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    abs64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

>>> src/lbf_setup.sv
`timescale 1ns / 1ps
// Derives gamma and k from the boost velocity after each register write.
// Sequential divider / square root / divider. Uses lbf_pkg.
module lbf_setup #(
  parameter int BETA_FRAC_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [2:0][BETA_FRAC_BITS:0]      beta,
  output lbf_pkg::lbf_factors_t             factors,
  output logic                              busy
);
  import lbf_pkg::*;

  localparam int BW = BETA_FRAC_BITS + 1;
  localparam int AW = 2 * BETA_FRAC_BITS + 2;
  localparam int DW = 2 * BETA_FRAC_BITS + 1;
  localparam int E  = 2 * FACTOR_FRAC + 2 * BETA_FRAC_BITS;
  localparam int CW = $clog2(E + 1);
  localparam logic [AW-1:0] ONE_B2 = AW'(1) << (2 * BETA_FRAC_BITS);
  localparam logic [DW-1:0] D_LIM  = DW'(1) << (E - 64);
  localparam logic [CW-1:0] E_CNT  = CW'(E);

  su_state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r;
  logic [AW-1:0]   acc_r, rem_r;
  logic [DW-1:0]   d_r;
  logic [63:0]     q_r, x_r, res_r, bit_r, prod_r;
  logic [31:0]     g_r;
  logic [32:0]     div_r;
  logic [33:0]     krem_r;
  lbf_factors_t    factors_r;

  logic signed [BW-1:0]   bsel;
  logic signed [2*BW-1:0] sq;
  logic                   inv, d_small;
  logic [DW-1:0]          d_w;
  logic [AW-1:0]          rem_s, rem_n;
  logic                   div_ge;
  logic [63:0]            q_n, sq_t, res_n;
  logic                   sq_ge;
  logic [33:0]            kr_s, kr_n;
  logic                   k_ge;
  logic [63:0]            prod_n;

  always_comb begin
    bsel    = signed'(beta[cnt_r[1:0]]);
    sq      = bsel * bsel;
    inv     = acc_r >= ONE_B2;
    d_w     = DW'(ONE_B2 - acc_r);
    d_small = d_w <= D_LIM;
    rem_s   = {rem_r[AW-2:0], cnt_r == E_CNT};
    div_ge  = rem_s >= AW'(d_r);
    rem_n   = div_ge ? rem_s - AW'(d_r) : rem_s;
    q_n     = {q_r[62:0], div_ge};
    sq_t    = res_r + bit_r;
    sq_ge   = x_r >= sq_t;
    res_n   = sq_ge ? (res_r >> 1) + bit_r : res_r >> 1;
    kr_s    = {krem_r[32:0], prod_r[63]};
    k_ge    = kr_s >= {1'b0, div_r};
    kr_n    = k_ge ? kr_s - {1'b0, div_r} : kr_s;
    prod_n  = {prod_r[62:0], k_ge};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SU_IDLE:  state_nxt = SU_IDLE;
      SU_SUM:   if (cnt_r == CW'(2)) state_nxt = SU_CHECK;
      SU_CHECK: state_nxt = (inv || d_small) ? SU_IDLE : SU_DIV;
      SU_DIV:   if (cnt_r == '0) state_nxt = SU_SQRT;
      SU_SQRT:  if (cnt_r == '0) state_nxt = SU_MUL;
      SU_MUL:   state_nxt = SU_KDIV;
      SU_KDIV:  if (cnt_r == '0) state_nxt = SU_IDLE;
      default:  state_nxt = SU_IDLE;
    endcase
    if (start) state_nxt = SU_SUM;
  end

  always_comb begin
    busy    = state_r != SU_IDLE;
    factors = factors_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= SU_IDLE;
      cnt_r     <= '0;
      factors_r <= '{gamma: FACTOR_ONE, k: FACTOR_HALF, vok: 1'b1};
    end else begin
      state_r <= state_nxt;
      if (start) begin
        cnt_r <= '0;
        acc_r <= '0;
      end else begin
        case (state_r)
          SU_SUM: begin
            acc_r <= acc_r + AW'(sq);
            cnt_r <= cnt_r + CW'(1);
          end
          SU_CHECK: begin
            if (inv) begin
              factors_r <= '{gamma: '0, k: '0, vok: 1'b0};
            end else if (d_small) begin
              factors_r <= '{gamma: FACTOR_MAX, k: FACTOR_MAX, vok: 1'b1};
            end
            d_r   <= d_w;
            rem_r <= '0;
            q_r   <= '0;
            cnt_r <= E_CNT;
          end
          SU_DIV: begin
            rem_r <= rem_n;
            q_r   <= q_n;
            cnt_r <= cnt_r - CW'(1);
            if (cnt_r == '0) begin
              x_r   <= q_n;
              res_r <= '0;
              bit_r <= 64'h4000_0000_0000_0000;
              cnt_r <= CW'(31);
            end
          end
          SU_SQRT: begin
            if (sq_ge) x_r <= x_r - sq_t;
            res_r <= res_n;
            bit_r <= bit_r >> 2;
            cnt_r <= cnt_r - CW'(1);
            g_r   <= res_n[31:0];
          end
          SU_MUL: begin
            prod_r <= 64'(g_r) * 64'(g_r);
            div_r  <= {1'b0, g_r} + 33'(FACTOR_ONE);
            krem_r <= '0;
            cnt_r  <= CW'(63);
          end
          SU_KDIV: begin
            krem_r <= kr_n;
            prod_r <= prod_n;
            cnt_r  <= cnt_r - CW'(1);
            if (cnt_r == '0) begin
              factors_r <= '{gamma: g_r, k: prod_n[31:0], vok: 1'b1};
            end
          end
          default: cnt_r <= cnt_r;
        endcase
      end
    end
  end

endmodule

>>> src/lorentz_boost_four_vector.sv
`timescale 1ns / 1ps
// Lorentz boost of four-vectors along a programmable velocity; top level.
// Depends on lbf_pkg and lbf_setup.
//
// Takes one four-vector per clock while in_tready is high and returns its
// boosted form through an eight-stage pipeline; a stalled output backs up stage by
// stage. Each write of beta_x/y/z starts the factor setup (squares, long
// division, square root, second division). in_tready is low in the write
// cycle and while the setup runs; the setup ends early, after the range check,
// when the velocity is invalid or gamma overflows.
// Status: 0 ok, 1 invalid velocity (coordinates zero), 2 saturated.
module lorentz_boost_four_vector #(
  parameter int COORD_WIDTH    = 32,
  parameter int BETA_FRAC_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // time_comp, pos_x, pos_y, pos_z
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // boosted_time, boosted_x, boosted_y, boosted_z
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]   out_tdata,
  // status
  output logic [lbf_pkg::STATUS_W-1:0]         out_tuser,
  input  logic                                 cfg_wr_en,
  input  logic [lbf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [BETA_FRAC_BITS:0]              cfg_wdata
);
  import lbf_pkg::*;

  localparam int C     = COORD_WIDTH;
  localparam int B     = BETA_FRAC_BITS;
  localparam int BW    = B + 1;
  localparam int PMW   = BW + C;
  localparam int GMW   = FACTOR_W + C;
  localparam int DW    = ((4 * C + 7) / 8) * 8;
  localparam int NST   = 8;
  localparam int SH_G  = FACTOR_FRAC - B;
  localparam int SH_T  = FACTOR_FRAC + B;
  localparam int SH_F  = 2 * B;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (C - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  logic [2:0][BW-1:0] beta_r;
  lbf_factors_t       fac;
  logic               su_busy, cfg_hit, accept;
  logic [NST-1:0]     v_r, en;

  logic [2:0][BW-1:0] babs;
  logic [2:0]         bneg;

  assign cfg_hit = cfg_wr_en && (cfg_index <= REG_BETA_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= '0;
    end else if (cfg_hit) begin
      beta_r[cfg_index] <= cfg_wdata;
    end
  end

  lbf_setup #(.BETA_FRAC_BITS(B)) u_setup (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_hit),
    .beta    (beta_r),
    .factors (fac),
    .busy    (su_busy)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bneg[i] = beta_r[i][BW-1];
      babs[i] = bneg[i] ? BW'(-beta_r[i]) : beta_r[i];
    end
  end

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_tready;
    for (int i = NST - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign in_tready = en[0] && !su_busy && !cfg_hit;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= accept;
      for (int i = 1; i < NST; i++) if (en[i]) v_r[i] <= v_r[i-1];
    end
  end

  // stage 0: beta.r lane products, gamma*|ct|
  logic signed [C-1:0]  in_ct;
  logic [2:0][C-1:0]    in_r;
  logic [C-1:0]         ctabs_w;
  logic [2:0][C-1:0]    rabs_w;
  logic [2:0][C-1:0]    s0_r_r;
  logic [2:0][PMW-1:0]  s0_pm_r;
  logic [2:0]           s0_pneg_r;
  logic [GMW-1:0]       s0_gm_r;
  logic [C-1:0]         s0_ctabs_r;
  logic                 s0_ctneg_r;

  always_comb begin
    in_ct   = signed'(in_tdata[C-1:0]);
    ctabs_w = in_ct[C-1] ? C'(-in_ct) : C'(in_ct);
    for (int i = 0; i < 3; i++) begin
      in_r[i]   = in_tdata[(i+1)*C +: C];
      rabs_w[i] = in_r[i][C-1] ? C'(-in_r[i]) : in_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        s0_pm_r[i]   <= PMW'(babs[i]) * PMW'(rabs_w[i]);
        s0_pneg_r[i] <= bneg[i] ^ in_r[i][C-1];
      end
      s0_r_r     <= in_r;
      s0_gm_r    <= GMW'(fac.gamma) * GMW'(ctabs_w);
      s0_ctabs_r <= ctabs_w;
      s0_ctneg_r <= in_ct[C-1];
    end
  end

  // stage 1: p, gamma*ct, ct - p
  logic signed [63:0] p_w, ctb_w;
  logic [2:0][C-1:0]  s1_r_r;
  logic signed [63:0] s1_p_r, s1_gct_r, s1_ctd_r;

  always_comb begin
    p_w = '0;
    for (int i = 0; i < 3; i++) begin
      p_w = p_w + apply_sign(s0_pneg_r[i], clamp_mag(128'(s0_pm_r[i])));
    end
    ctb_w = apply_sign(s0_ctneg_r, clamp_mag(128'(s0_ctabs_r) << B));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_r_r   <= s0_r_r;
      s1_p_r   <= p_w;
      s1_gct_r <= apply_sign(s0_ctneg_r, clamp_mag(128'(s0_gm_r) >> SH_G));
      s1_ctd_r <= ctb_w - p_w;
    end
  end

  // stage 2: partial products k*|p| and gamma*|ct-p|
  logic [63:0]        pabs_w, ctdabs_w;
  logic [2:0][C-1:0]  s2_r_r;
  logic signed [63:0] s2_gct_r;
  logic [63:0]        s2_kp_lo_r, s2_kp_hi_r, s2_tp_lo_r, s2_tp_hi_r;
  logic               s2_pneg_r, s2_tneg_r;

  always_comb begin
    pabs_w   = abs64(s1_p_r);
    ctdabs_w = abs64(s1_ctd_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_r_r     <= s1_r_r;
      s2_gct_r   <= s1_gct_r;
      s2_kp_lo_r <= 64'(fac.k) * 64'(pabs_w[31:0]);
      s2_kp_hi_r <= 64'(fac.k) * 64'(pabs_w[63:32]);
      s2_tp_lo_r <= 64'(fac.gamma) * 64'(ctdabs_w[31:0]);
      s2_tp_hi_r <= 64'(fac.gamma) * 64'(ctdabs_w[63:32]);
      s2_pneg_r  <= s1_p_r[63];
      s2_tneg_r  <= s1_ctd_r[63];
    end
  end

  // stage 3: combine partials, truncate, clamp
  logic [127:0]       kprod_w, tprod_w;
  logic [2:0][C-1:0]  s3_r_r;
  logic signed [63:0] s3_gct_r, s3_kp_r, s3_t_r;

  always_comb begin
    kprod_w = (128'(s2_kp_hi_r) << 32) + 128'(s2_kp_lo_r);
    tprod_w = (128'(s2_tp_hi_r) << 32) + 128'(s2_tp_lo_r);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_r_r   <= s2_r_r;
      s3_gct_r <= s2_gct_r;
      s3_kp_r  <= apply_sign(s2_pneg_r, clamp_mag(kprod_w >> FACTOR_FRAC));
      s3_t_r   <= apply_sign(s2_tneg_r, clamp_mag(tprod_w >> SH_T));
    end
  end

  // stage 4: f = k*p - gamma*ct, saturate time
  logic [2:0][C-1:0]  s4_r_r;
  logic signed [63:0] s4_f_r;
  logic [C-1:0]       s4_t_r;
  logic               s4_tsat_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_r_r    <= s3_r_r;
      s4_f_r    <= s3_kp_r - s3_gct_r;
      s4_tsat_r <= (s3_t_r > SAT_HI) || (s3_t_r < SAT_LO);
      if (s3_t_r > SAT_HI)      s4_t_r <= C'(SAT_HI);
      else if (s3_t_r < SAT_LO) s4_t_r <= C'(SAT_LO);
      else                      s4_t_r <= C'(s3_t_r);
    end
  end

  // stage 5: f*beta partial products
  localparam int FPW = 32 + BW;
  logic [63:0]          fabs_w;
  logic [2:0][C-1:0]    s5_r_r;
  logic [C-1:0]         s5_t_r;
  logic                 s5_tsat_r;
  logic [2:0][FPW-1:0]  s5_lo_r, s5_hi_r;
  logic [2:0]           s5_neg_r;

  assign fabs_w = abs64(s4_f_r);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_r_r    <= s4_r_r;
      s5_t_r    <= s4_t_r;
      s5_tsat_r <= s4_tsat_r;
      for (int i = 0; i < 3; i++) begin
        s5_lo_r[i]  <= FPW'(fabs_w[31:0]) * FPW'(babs[i]);
        s5_hi_r[i]  <= FPW'(fabs_w[63:32]) * FPW'(babs[i]);
        s5_neg_r[i] <= s4_f_r[63] ^ bneg[i];
      end
    end
  end

  // stage 6: combine lanes, truncate, clamp
  logic [2:0][127:0]    fb_w;
  logic [2:0][C-1:0]    s6_r_r;
  logic [C-1:0]         s6_t_r;
  logic                 s6_tsat_r;
  logic signed [63:0]   s6_term_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fb_w[i] = (128'(s5_hi_r[i]) << 32) + 128'(s5_lo_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_r_r    <= s5_r_r;
      s6_t_r    <= s5_t_r;
      s6_tsat_r <= s5_tsat_r;
      for (int i = 0; i < 3; i++) begin
        s6_term_r[i] <= apply_sign(s5_neg_r[i], clamp_mag(fb_w[i] >> SH_F));
      end
    end
  end

  // stage 7: r + f*beta, saturate, status (output register)
  logic signed [63:0]   sum_w [3];
  logic [2:0][C-1:0]    sp_w;
  logic [2:0]           ssat_w;
  logic [C-1:0]         s7_t_r;
  logic [2:0][C-1:0]    s7_r_r;
  logic [STATUS_W-1:0]  s7_st_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_w[i]  = 64'(signed'(s6_r_r[i])) + s6_term_r[i];
      ssat_w[i] = (sum_w[i] > SAT_HI) || (sum_w[i] < SAT_LO);
      if (sum_w[i] > SAT_HI)      sp_w[i] = C'(SAT_HI);
      else if (sum_w[i] < SAT_LO) sp_w[i] = C'(SAT_LO);
      else                        sp_w[i] = C'(sum_w[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      if (!fac.vok) begin
        s7_t_r  <= '0;
        s7_r_r  <= '0;
        s7_st_r <= ST_INVALID;
      end else begin
        s7_t_r  <= s6_t_r;
        s7_r_r  <= sp_w;
        s7_st_r <= (s6_tsat_r || (|ssat_w) || (fac.gamma == FACTOR_MAX)) ? ST_SAT : ST_OK;
      end
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = DW'({s7_r_r, s7_t_r});
  assign out_tuser  = s7_st_r;

`ifndef NO_ASSERTIONS
  a_no_accept_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !su_busy)
    else $error("item accepted during factor setup");

  a_write_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en && (cfg_index <= REG_BETA_Z) |=> su_busy)
    else $error("register write did not start setup");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !fac.vok |-> (out_tuser == ST_INVALID) && (out_tdata == '0))
    else $error("invalid velocity result not zeroed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK) || (out_tuser == ST_INVALID) ||
                   (out_tuser == ST_SAT))
    else $error("undefined status code");
`endif

endmodule

>>> tb/boost_checker.sv
`timescale 1ns / 1ps
// Scoreboard for lorentz_boost_four_vector: follows velocity writes, predicts each
// boosted four-vector and compares it with the output item. Depends on lbf_pkg.
module boost_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  output int           fail_count,
  output int           pending
);
  import lbf_pkg::*;

  typedef struct {
    logic [31:0] coord [4];
    logic [1:0]  status;
  } boosted_t;

  boosted_t           boosted_q [$];
  logic signed [15:0] beta [3];
  logic [31:0]        gamma_f;
  logic [31:0]        k_f;
  logic               vel_ok;

  // exact product, truncated toward zero, magnitude limited to 2^60
  function automatic logic signed [127:0] mul_trunc(input logic signed [127:0] a,
                                                    input logic signed [127:0] b,
                                                    input int sh);
    logic [127:0] ua, ub, m;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    m   = (ua * ub) >> sh;
    if (m > (128'd1 << 60)) m = 128'd1 << 60;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic update_factors();
    logic [127:0] b2, d, q, g;
    b2 = 0;
    for (int i = 0; i < 3; i++) b2 += 128'(beta[i]) * 128'(beta[i]);
    if (b2 >= (128'd1 << 30)) begin
      vel_ok = 0; gamma_f = 0; k_f = 0;
    end else begin
      vel_ok = 1;
      d = (128'd1 << 30) - b2;
      if (d <= (128'd1 << 14)) begin
        gamma_f = FACTOR_MAX; k_f = FACTOR_MAX;
      end else begin
        q = (128'd1 << 78) / d;
        g = 128'(int_sqrt(q[63:0]));
        if (g > 128'(FACTOR_MAX)) g = 128'(FACTOR_MAX);
        gamma_f = g[31:0];
        k_f     = 32'((g * g) / (g + (128'd1 << 24)));
      end
    end
  endtask

  function automatic boosted_t boost(input logic [127:0] d);
    boosted_t           res;
    logic signed [127:0] ct, r [3], p, f, ctd, v;
    logic                sat;
    if (!vel_ok) begin
      for (int i = 0; i < 4; i++) res.coord[i] = '0;
      res.status = ST_INVALID;
      return res;
    end
    sat = (gamma_f == FACTOR_MAX);
    ct  = 128'($signed(d[31:0]));
    p   = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = 128'($signed(d[32*i+32 +: 32]));
      p    = p + mul_trunc(128'(beta[i]), r[i], 0);
    end
    f   = mul_trunc({96'd0, k_f}, p, 24) - mul_trunc({96'd0, gamma_f}, ct, 9);
    ctd = mul_trunc(ct, 128'sd32768, 0) - p;
    for (int i = 0; i < 4; i++) begin
      v = (i == 0) ? mul_trunc({96'd0, gamma_f}, ctd, 39)
                   : r[i-1] + mul_trunc(f, 128'(beta[i-1]), 30);
      if (v > 128'sh7FFF_FFFF) begin
        v = 128'sh7FFF_FFFF; sat = 1;
      end else if (v < -128'sh8000_0000) begin
        v = -128'sh8000_0000; sat = 1;
      end
      res.coord[i] = v[31:0];
    end
    res.status = sat ? ST_SAT : ST_OK;
    return res;
  endfunction

  always @(posedge clk) begin
    boosted_t want;
    if (!rst_n) begin
      beta       = '{default: '0};
      gamma_f    = FACTOR_ONE;
      k_f        = FACTOR_HALF;
      vel_ok     = 1;
      fail_count = 0;
      boosted_q.delete();
      pending    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (boosted_q.size() == 0) begin
          $display("%0t: unexpected item %h status %0d", $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = boosted_q.pop_front();
          for (int i = 0; i < 4; i++)
            if (out_tdata[32*i +: 32] !== want.coord[i]) begin
              $display("%0t: coord %0d expected %h actual %h", $time, i,
                       want.coord[i], out_tdata[32*i +: 32]);
              fail_count++;
            end
          if (out_tuser !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) boosted_q.insert(boosted_q.size(), boost(in_tdata));
      if (cfg_wr_en && cfg_index <= REG_BETA_Z) begin
        beta[cfg_index] = cfg_wdata;
        update_factors();
      end
      pending = boosted_q.size();
    end
  end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the lorentz_boost_four_vector test: clock, reset, velocity writes,
// four-vector stimulus, output backpressure and verdict. Depends on boost_checker.
module testbench;
  import lbf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid, in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid, out_tready;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_wr_en;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_wdata;
  int           fail_count, pending;
  int           idle_mode;
  logic         hold_req;
  int           quiet;

  lorentz_boost_four_vector u_dut (.*);

  boost_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2, 3: return 32'($signed($urandom_range(2097151)) - 1048576);
      4:    return 32'($signed($urandom_range(131071)) - 65536) <<< 8;
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  task automatic send_vector(input logic [127:0] d);
    if (idle_mode != 2)
      while ($urandom_range(99) < ((idle_mode == 0) ? 32 : 68)) begin
        in_tvalid <= 0;
        @(posedge clk);
      end
    in_tvalid <= 1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    repeat (2) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic set_velocity(input logic [15:0] bx, by, bz);
    write_reg(REG_BETA_X, bx);
    write_reg(REG_BETA_Y, by);
    write_reg(REG_BETA_Z, bz);
  endtask

  task automatic run_vectors(input int n);
    for (int i = 0; i < n; i++)
      send_vector({rand_coord(), rand_coord(), rand_coord(), rand_coord()});
  endtask

  // receiver: random backpressure except in idle mode 2, plus one long hold-off on request
  initial begin
    logic hold_seen;
    hold_seen  = 0;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1;
        out_tready <= 0;
        repeat (300) @(posedge clk);
      end else if (idle_mode == 2) begin
        out_tready <= 1;
      end else begin
        out_tready <= ($urandom_range(99) >= ((idle_mode == 0) ? 68 : 32));
      end
    end
  end

  initial begin
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] cfgs [10][3];
    cfgs = '{'{16'sd32767, 0, 0}, '{-16'sd32767, 0, 0}, '{0, 16'sd32767, 0},
             '{0, 0, -16'sd32767}, '{16'sd32767, 16'sd222, 0},
             '{16'h8000, 0, 0}, '{16'sd32767, 16'sd32767, 16'sd32767},
             '{16'sd18000, -16'sd12000, 16'sd9000}, '{0, 0, 0},
             '{-16'sd20000, 16'sd20000, -16'sd15000}};
    rst_n     = 0;
    in_tvalid = 0;
    in_tdata  = '0;
    cfg_wr_en = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_req  = 0;
    idle_mode = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    // identity velocity, field extremes
    send_vector('0);
    send_vector({4{32'h8000_0000}});
    send_vector({4{32'h7FFF_FFFF}});
    send_vector({4{32'hFFFF_FFFF}});
    send_vector({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    send_vector({32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'h5555_AAAA});
    send_vector({32'hAAAA_5555, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000});
    run_vectors(13);
    drain();
    write_reg(REG_UNUSED, 16'h7FFF);
    run_vectors(5);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      idle_mode = (ph < 4) ? 0 : (ph < 8) ? 1 : 2;
      if (ph < 10)
        set_velocity(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2]);
      else
        set_velocity(16'($signed($urandom_range(36000)) - 18000),
                     16'($signed($urandom_range(36000)) - 18000),
                     16'($signed($urandom_range(36000)) - 18000));
      if (ph == 9) hold_req = 1;
      run_vectors(68);
      drain();
    end

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
